/* hw/rtl/rfa_pkg.sv */
package rfa_pkg;

	localparam int OperandWidth = 32;
	localparam int ResWidth = 64;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_COMB,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] left_numerator;
		logic [30:0] left_denominator;
		logic [31:0] right_numerator;
		logic [30:0] right_denominator;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_numerator;
		logic [62:0] result_denominator;
		logic        status;
	} out_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic comb;
		logic gcd_start;
		logic div_start;
		logic div_den;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} dp_stat_t;

endpackage

/* hw/rtl/rfa_ctrl.sv */
module rfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_taken,
	input  rfa_pkg::dp_stat_t stat,
	output rfa_pkg::dp_cmd_t  ctl,
	output logic              idle,
	output logic              busy_out
);

	rfa_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rfa_pkg::ST_IDLE: if (start) state_nx = rfa_pkg::ST_MUL1;
			rfa_pkg::ST_MUL1: state_nx = rfa_pkg::ST_MUL2;
			rfa_pkg::ST_MUL2: state_nx = rfa_pkg::ST_COMB;
			rfa_pkg::ST_COMB: state_nx = stat.early ? rfa_pkg::ST_DONE : rfa_pkg::ST_GCD;
			rfa_pkg::ST_GCD: if (stat.gcd_done) state_nx = rfa_pkg::ST_DIVN;
			rfa_pkg::ST_DIVN: if (stat.div_done) state_nx = rfa_pkg::ST_DIVD;
			rfa_pkg::ST_DIVD: if (stat.div_done) state_nx = rfa_pkg::ST_DONE;
			rfa_pkg::ST_DONE: if (out_taken) state_nx = rfa_pkg::ST_IDLE;
			default: state_nx = rfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		idle = 1'b0;
		busy_out = 1'b0;
		case (state_q)
			rfa_pkg::ST_IDLE: begin
				idle = 1'b1;
				ctl.load = start;
			end
			rfa_pkg::ST_MUL1: ctl.mul1 = 1'b1;
			rfa_pkg::ST_MUL2: ctl.mul2 = 1'b1;
			rfa_pkg::ST_COMB: begin
				ctl.comb = 1'b1;
				ctl.gcd_start = !stat.early;
			end
			rfa_pkg::ST_GCD: ctl.div_start = stat.gcd_done;
			rfa_pkg::ST_DIVN: begin
				ctl.div_start = stat.div_done;
				ctl.div_den = stat.div_done;
			end
			rfa_pkg::ST_DIVD: ctl = '0;
			rfa_pkg::ST_DONE: busy_out = 1'b1;
			default: ctl = '0;
		endcase
	end

endmodule

/* hw/rtl/rfa_datapath.sv */
module rfa_datapath #(
	parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rfa_pkg::in_word_t in_w,
	input  rfa_pkg::dp_cmd_t  ctl,
	output rfa_pkg::dp_stat_t stat,
	output rfa_pkg::out_word_t out_w
);

	localparam int W = rfa_pkg::ResWidth;
	localparam int CW = $clog2(W + 1);

	logic [1:0] cmd_q;
	logic signed [31:0] ln_q, ld_q, rn_q, rd_q;
	logic signed [63:0] p1_q, p2_q, den_q;
	logic [63:0] nm_q, dm_q, a_q, b_q;
	logic neg_q, early_q, err_q;
	logic gcd_q, dvb_q;
	// Shared restoring divider, one quotient bit per cycle.
	logic [63:0] dq_q, dr_q, dd_q;
	logic [CW-1:0] dcnt_q;
	logic dsel_q, gsel_q;
	logic [64:0] trial;
	logic signed [63:0] num_c;
	logic signed [31:0] ln_x, rn_x;
	logic [63:0] mag_n, mag_d;
	logic div_fin;
	logic gcd_end;

	assign ln_x = 32'(signed'(in_w.left_numerator[OPERAND_WIDTH-1:0]));
	assign rn_x = 32'(signed'(in_w.right_numerator[OPERAND_WIDTH-1:0]));
	assign trial = {dr_q, dq_q[63]} - {1'b0, dd_q};
	assign div_fin = dvb_q && (dcnt_q == '0);
	assign gcd_end = gcd_q && !dvb_q && (b_q == 64'd0);

	always_comb begin
		case (cmd_q)
			rfa_pkg::CMD_ADD: num_c = p1_q + p2_q;
			rfa_pkg::CMD_SUB: num_c = p1_q - p2_q;
			default: num_c = p1_q;
		endcase
		mag_n = num_c[63] ? 64'(-num_c) : 64'(num_c);
		mag_d = den_q[63] ? 64'(-den_q) : 64'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcd_q <= 1'b0;
			dvb_q <= 1'b0;
			early_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				cmd_q <= in_w.cmd;
				ln_q <= ln_x;
				rn_q <= rn_x;
				ld_q <= 32'(in_w.left_denominator[OPERAND_WIDTH-2:0]);
				rd_q <= 32'(in_w.right_denominator[OPERAND_WIDTH-2:0]);
			end
			if (ctl.mul1) begin
				case (cmd_q)
					rfa_pkg::CMD_MUL: p1_q <= 64'(ln_q) * 64'(rn_q);
					default: p1_q <= 64'(ln_q) * 64'(rd_q);
				endcase
			end
			if (ctl.mul2) begin
				case (cmd_q)
					rfa_pkg::CMD_DIV: den_q <= 64'(ld_q) * 64'(rn_q);
					default: den_q <= 64'(ld_q) * 64'(rd_q);
				endcase
				p2_q <= 64'(rn_q) * 64'(ld_q);
			end
			if (ctl.comb) begin
				nm_q <= mag_n;
				dm_q <= mag_d;
				a_q <= mag_n;
				b_q <= mag_d;
				neg_q <= num_c[63] ^ den_q[63];
				err_q <= (den_q == 64'sd0);
				early_q <= (den_q == 64'sd0) || (num_c == 64'sd0);
			end else if (div_fin) begin
				// Write back: a Euclid round shifts the pair, the final
				// divisions replace numerator and denominator.
				if (gsel_q) begin
					a_q <= b_q;
					b_q <= dr_q;
				end else if (dsel_q) begin
					dm_q <= dq_q;
				end else begin
					nm_q <= dq_q;
				end
			end
			if (ctl.gcd_start) begin
				gcd_q <= 1'b1;
			end else if (gcd_end) begin
				gcd_q <= 1'b0;
			end
			// Once Euclid ends, a holds the GCD for both final divisions.
			if (ctl.div_start) begin
				dvb_q <= 1'b1;
				gsel_q <= 1'b0;
				dsel_q <= ctl.div_den;
				dq_q <= ctl.div_den ? dm_q : nm_q;
				dr_q <= '0;
				dd_q <= a_q;
				dcnt_q <= CW'(W);
			end else if (gcd_q && !dvb_q && (b_q != 64'd0)) begin
				// Euclid: each round is a full division of a by b.
				dvb_q <= 1'b1;
				gsel_q <= 1'b1;
				dq_q <= a_q;
				dr_q <= '0;
				dd_q <= b_q;
				dcnt_q <= CW'(W);
			end else if (dvb_q) begin
				if (dcnt_q != '0) begin
					dcnt_q <= dcnt_q - CW'(1);
					if (!trial[64]) begin
						dr_q <= trial[63:0];
						dq_q <= {dq_q[62:0], 1'b1};
					end else begin
						dr_q <= {dr_q[62:0], dq_q[63]};
						dq_q <= {dq_q[62:0], 1'b0};
					end
				end else begin
					dvb_q <= 1'b0;
				end
			end
		end
	end

	assign stat.early = (den_q == 64'sd0) || (num_c == 64'sd0);
	assign stat.gcd_done = gcd_end;
	assign stat.div_done = div_fin && !gsel_q;

	always_comb begin
		if (early_q) begin
			out_w.result_numerator = '0;
			out_w.result_denominator = 63'd1;
			out_w.status = err_q;
		end else begin
			out_w.result_numerator = neg_q ? 64'(-nm_q) : nm_q;
			out_w.result_denominator = dm_q[62:0];
			out_w.status = 1'b0;
		end
	end

endmodule

/* hw/rtl/rational_fraction_alu_top.sv */
// Exact fraction arithmetic: each input word holds two fractions and an
// operation (add, subtract, multiply, divide); the result word is the reduced
// fraction with a positive denominator, 0/1 for a zero result, and 0/1 with
// status set when the result denominator is zero (divide by a zero fraction).
// The block works on one word at a time. A word passes the multiply states MUL1
// and MUL2 and the combine state COMB; a zero or errored result goes to the output
// right after. Otherwise the Euclidean GCD follows, each remainder step one
// full pass of the shared bit-serial divider (a load, 64 quotient bits, a
// write-back), then two back-to-back divisions by the GCD. The longest GCD
// chains on 63-bit magnitudes run about 92 steps. The result waits in the
// output until taken, and no new word is accepted before that.
module rational_fraction_alu_top #(
	parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rfa_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rfa_pkg::out_word_t out_data
);

	rfa_pkg::dp_cmd_t  ctl;
	rfa_pkg::dp_stat_t stat;
	logic idle;

	rfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.start(in_valid), .out_taken(out_ready),
		.stat(stat), .ctl(ctl), .idle(idle), .busy_out(out_valid)
	);

	rfa_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_w(in_data), .ctl(ctl), .stat(stat), .out_w(out_data)
	);

	assign in_ready = idle;

endmodule

/* hw/rtl/rfa_checker.sv */
module rfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input rfa_pkg::out_word_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word withdrawn before it was taken");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.result_denominator != 63'd0)
		else $error("zero denominator");
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.result_numerator == 64'd0)
		else $error("error result not zero");

endmodule

bind rational_fraction_alu_top rfa_checker u_rfa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* sim/tb.sv */
module tb;

	// Cycles without any accepted word before the run is declared hung. The limit
	// has to cover a word's longest GCD work plus a receiver stall.
	localparam int HangLimit = 50000;
	localparam int RandomWords = 1000;
	localparam int DrainCycles = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rfa_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rfa_pkg::out_word_t out_data;

	rational_fraction_alu_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reduced fractions still owed by the block, oldest first.
	rfa_pkg::out_word_t owed_fractions[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit calm_phase = 1'b0;

	// Euclid on the magnitudes, written in terms of 64-bit vectors.
	function automatic logic [63:0] gcd64(input logic [63:0] a_in, input logic [63:0] b_in);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		a = a_in;
		b = b_in;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// Computes the reduced fraction that one input word should produce.
	function automatic rfa_pkg::out_word_t reduce_fraction(input rfa_pkg::in_word_t w);
		longint ln;
		longint ld;
		longint rn;
		longint rd;
		longint num;
		longint den;
		logic [63:0] nmag;
		logic [63:0] dmag;
		logic [63:0] g;
		logic neg;
		rfa_pkg::out_word_t r;
		ln = longint'($signed(w.left_numerator));
		rn = longint'($signed(w.right_numerator));
		ld = longint'({33'd0, w.left_denominator});
		rd = longint'({33'd0, w.right_denominator});
		case (rfa_pkg::cmd_t'(w.cmd))
			rfa_pkg::CMD_ADD: begin
				num = ln * rd + rn * ld;
				den = ld * rd;
			end
			rfa_pkg::CMD_SUB: begin
				num = ln * rd - rn * ld;
				den = ld * rd;
			end
			rfa_pkg::CMD_MUL: begin
				num = ln * rn;
				den = ld * rd;
			end
			default: begin
				num = ln * rd;
				den = ld * rn;
			end
		endcase
		r.result_numerator = 64'd0;
		r.result_denominator = 63'd1;
		r.status = 1'b0;
		if (den == 0) begin
			r.status = 1'b1;
		end else if (num != 0) begin
			nmag = (num < 0) ? -num : num;
			dmag = (den < 0) ? -den : den;
			neg = (num < 0) != (den < 0);
			g = gcd64(nmag, dmag);
			nmag = nmag / g;
			dmag = dmag / g;
			r.result_numerator = neg ? -nmag : nmag;
			r.result_denominator = dmag[62:0];
		end
		return r;
	endfunction

	// One row of the directed table. Where has_answer is set, the answer column is
	// taken as the expectation; otherwise the predictor fills it in.
	typedef struct {
		rfa_pkg::in_word_t word;
		bit has_answer;
		rfa_pkg::out_word_t answer;
	} directed_row_t;

	directed_row_t directed_rows[$];

	function automatic rfa_pkg::in_word_t make_word(input rfa_pkg::cmd_t c,
			input logic [31:0] ln, input logic [30:0] ld, input logic [31:0] rn,
			input logic [30:0] rd);
		rfa_pkg::in_word_t w;
		w.cmd = c;
		w.left_numerator = ln;
		w.left_denominator = ld;
		w.right_numerator = rn;
		w.right_denominator = rd;
		return w;
	endfunction

	function automatic rfa_pkg::out_word_t make_fraction(input logic [63:0] n,
			input logic [62:0] d, input logic s);
		rfa_pkg::out_word_t r;
		r.result_numerator = n;
		r.result_denominator = d;
		r.status = s;
		return r;
	endfunction

	task automatic add_row(input rfa_pkg::in_word_t w, input bit known,
			input rfa_pkg::out_word_t ans);
		directed_row_t row;
		row.word = w;
		row.has_answer = known;
		row.answer = ans;
		directed_rows.push_back(row);
	endtask

	// Random operand drawn mostly small, sometimes near the extremes, so that both
	// short and long GCD chains show up and every bit toggles.
	function automatic logic [31:0] pick_numerator();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2, 3: return $urandom;
			4: return 32'd0;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	function automatic logic [30:0] pick_denominator();
		case ($urandom_range(0, 9))
			0: return 31'h7fff_ffff - $urandom_range(0, 3);
			1, 2: return $urandom | 31'd1;
			3: return ($urandom % 200) + 1;
			default: return $urandom_range(1, 1000);
		endcase
	endfunction

	// Sends one word, with an optional random gap first, and records its expectation.
	// Valid stays high into the next word when no gap is drawn.
	task automatic send_word(input rfa_pkg::in_word_t w,
			input rfa_pkg::out_word_t expected_fraction);
		int gap;
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		owed_fractions.push_back(expected_fraction);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Receiver side: accepts result words and stalls in random bursts.
	initial begin : receiver
		int stall;
		rfa_pkg::out_word_t want;
		@(posedge arst_n);
		forever begin
			if (!calm_phase && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 12);
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (owed_fractions.size() == 0) begin
					$error("result word with nothing expected: %h", out_data);
					error_count++;
				end else begin
					want = owed_fractions.pop_front();
					if (out_data.result_numerator !== want.result_numerator) begin
						$error("result_numerator: expected %0d, got %0d",
							$signed(want.result_numerator), $signed(out_data.result_numerator));
						error_count++;
					end
					if (out_data.result_denominator !== want.result_denominator) begin
						$error("result_denominator: expected %0d, got %0d",
							want.result_denominator, out_data.result_denominator);
						error_count++;
					end
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						error_count++;
					end
				end
			end
		end
	end

	// Hang detector: counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HangLimit) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		rfa_pkg::in_word_t w;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, every operation, divide by zero, zero result,
		// and the out-of-range zero denominators.
		add_row(make_word(rfa_pkg::CMD_ADD, 32'd1, 31'd2, 32'd1, 31'd3), 1'b1,
			make_fraction(64'd5, 63'd6, 1'b0));
		add_row(make_word(rfa_pkg::CMD_SUB, 32'd1, 31'd2, 32'd1, 31'd2), 1'b1,
			make_fraction(64'd0, 63'd1, 1'b0));
		add_row(make_word(rfa_pkg::CMD_MUL, -32'sd2, 31'd3, 32'd3, 31'd4), 1'b1,
			make_fraction(-64'sd1, 63'd2, 1'b0));
		add_row(make_word(rfa_pkg::CMD_DIV, 32'd1, 31'd2, -32'sd1, 31'd4), 1'b1,
			make_fraction(-64'sd2, 63'd1, 1'b0));
		add_row(make_word(rfa_pkg::CMD_DIV, 32'd7, 31'd5, 32'd0, 31'd9), 1'b1,
			make_fraction(64'd0, 63'd1, 1'b1));
		add_row(make_word(rfa_pkg::CMD_ADD, 32'd3, 31'd0, 32'd1, 31'd1), 1'b1,
			make_fraction(64'd0, 63'd1, 1'b1));
		add_row(make_word(rfa_pkg::CMD_MUL, 32'd3, 31'd1, 32'd1, 31'd0), 1'b1,
			make_fraction(64'd0, 63'd1, 1'b1));
		add_row(make_word(rfa_pkg::CMD_MUL, 32'd0, 31'd5, 32'd9, 31'd7), 1'b1,
			make_fraction(64'd0, 63'd1, 1'b0));
		add_row(make_word(rfa_pkg::CMD_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1),
			1'b1, make_fraction(64'h4000_0000_0000_0000, 63'd1, 1'b0));
		add_row(make_word(rfa_pkg::CMD_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff,
			31'h7fff_ffff), 1'b0, '0);
		add_row(make_word(rfa_pkg::CMD_SUB, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff,
			31'd1), 1'b0, '0);
		add_row(make_word(rfa_pkg::CMD_ADD, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1),
			1'b0, '0);
		add_row(make_word(rfa_pkg::CMD_DIV, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000,
			31'h7fff_ffff), 1'b0, '0);
		add_row(make_word(rfa_pkg::CMD_DIV, 32'h7fff_ffff, 31'd1, 32'h8000_0000,
			31'h7fff_ffff), 1'b0, '0);
		add_row(make_word(rfa_pkg::CMD_MUL, 32'h7fff_ffff, 31'h7fff_fffe, -32'sd1,
			31'h7fff_ffff), 1'b0, '0);
		add_row(make_word(rfa_pkg::CMD_SUB, 32'd1, 31'h4000_0000, 32'd1, 31'h2aaa_aaab),
			1'b0, '0);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].word, directed_rows[i].has_answer ?
				directed_rows[i].answer : reduce_fraction(directed_rows[i].word));
		end

		// Random part; the final stretch runs with both sides at full rate.
		for (n = 0; n < RandomWords; n++) begin
			if (n == RandomWords - 100) calm_phase = 1'b1;
			w.cmd = $urandom_range(0, 3);
			w.left_numerator = pick_numerator();
			w.left_denominator = pick_denominator();
			w.right_numerator = pick_numerator();
			w.right_denominator = pick_denominator();
			send_word(w, reduce_fraction(w));
		end
		in_valid <= 1'b0;

		while (owed_fractions.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

/* rational_fraction_alu_top.f */
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_ctrl.sv
hw/rtl/rfa_datapath.sv
hw/rtl/rational_fraction_alu_top.sv
hw/rtl/rfa_checker.sv
sim/tb.sv
